### src/sosc_pkg.sv
// ----------------------------------------------------------------------------
// Spiral scan package
// Shared constants, types and helper functions of the spiral scan unit.
// ----------------------------------------------------------------------------
package sosc_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DATA_WIDTH = 32;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int DIMV_W     = 7;
  localparam int BND_W      = DIM_W + 2;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 13;
  localparam int DCNT_W     = $clog2(CNT_W + 1);
  localparam int ELEM_W     = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef enum logic {
    PH_LOAD,
    PH_EMIT
  } phase_t;

  typedef enum logic [1:0] {
    SD_TOP,
    SD_RIGHT,
    SD_BOTTOM,
    SD_LEFT
  } side_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              full;
    logic              busy;
  } ld_stat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              last;
  } wk_stat_t;

  // Saturates a dimension register to the range one to MAX_DIM.
  function automatic logic [DIM_W:0] clamp_dim(input logic [DIMV_W-1:0] v);
    logic [DIM_W:0] res;
    if (v == '0) begin
      res = (DIM_W+1)'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = (DIM_W+1)'(MAX_DIM);
    end else begin
      res = (DIM_W+1)'(v);
    end
    return res;
  endfunction

endpackage

### src/sosc_if.sv
// ----------------------------------------------------------------------------
// Spiral scan channels
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface sosc_in_if;
  import sosc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [ELEM_W-1:0] element_in;

  modport source (output valid, output action, output element_in, input ready);
  modport sink (input valid, input action, input element_in, output ready);
endinterface

interface sosc_out_if;
  import sosc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_out;
  logic                     is_last;

  modport source (output valid, output element_out, output is_last, input ready);
  modport sink (input valid, input element_out, input is_last, output ready);
endinterface

### src/sosc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sosc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sosc_loader.sv
// ----------------------------------------------------------------------------
// Spiral scan loader
// Tracks the row-major load position and rebuilds it by a serial divide
// whenever the column count register is written.
// ----------------------------------------------------------------------------
module sosc_loader (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_fire,
  input  logic                          cols_wr,
  input  logic [sosc_pkg::DIM_W:0]      rows,
  input  logic [sosc_pkg::DIM_W:0]      cols,
  output sosc_pkg::ld_stat_t            stat
);
  import sosc_pkg::*;

  logic [CNT_W-1:0]  load_count_r, load_count_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [DIM_W:0]    rem_r, rem_nxt;
  logic [DIM_W+1:0]  trial;
  logic              qbit;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  total;
  logic              col_wrap;

  assign count_inc = load_count_r + CNT_W'(1);
  assign total     = CNT_W'(rows) * CNT_W'(cols);
  assign col_wrap  = ({1'b0, col_r} + (DIM_W+1)'(1)) == cols;
  assign trial     = {rem_r, quo_r[CNT_W-1]};
  assign qbit      = trial >= (DIM_W+2)'(cols);

  always_comb begin
    load_count_nxt = load_count_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    div_cnt_nxt    = div_cnt_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    if (cols_wr) begin
      quo_nxt     = load_count_r;
      rem_nxt     = '0;
      div_cnt_nxt = DCNT_W'(CNT_W);
    end else if (div_cnt_r != '0) begin
      quo_nxt     = {quo_r[CNT_W-2:0], qbit};
      rem_nxt     = qbit ? (DIM_W+1)'(trial - (DIM_W+2)'(cols)) : trial[DIM_W:0];
      div_cnt_nxt = div_cnt_r - DCNT_W'(1);
      if (div_cnt_r == DCNT_W'(1)) begin
        row_nxt = quo_nxt;
        col_nxt = rem_nxt[DIM_W-1:0];
      end
    end else if (load_fire) begin
      if (count_inc >= total) begin
        load_count_nxt = '0;
        row_nxt        = '0;
        col_nxt        = '0;
      end else begin
        load_count_nxt = count_inc;
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_r + CNT_W'(1);
        end else begin
          col_nxt = col_r + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      row_r        <= '0;
      col_r        <= '0;
      div_cnt_r    <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      div_cnt_r    <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    stat.wr_en   = load_fire && (32'(row_r) < MAX_DIM);
    stat.wr_addr = ADDR_W'(32'(row_r[DIM_W-1:0]) * MAX_DIM + 32'(col_r));
    stat.full    = count_inc >= total;
    stat.busy    = div_cnt_r != '0;
  end

endmodule

### src/sosc_walker.sv
// ----------------------------------------------------------------------------
// Spiral scan walker
// Holds the ring bounds, the current side and the cursor, and produces the
// read address and end flag of each spiral step.
// ----------------------------------------------------------------------------
module sosc_walker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     step,
  input  logic [sosc_pkg::DIM_W:0] rows,
  input  logic [sosc_pkg::DIM_W:0] cols,
  output sosc_pkg::wk_stat_t       stat
);
  import sosc_pkg::*;

  logic signed [BND_W-1:0] top_r, top_nxt;
  logic signed [BND_W-1:0] bot_r, bot_nxt;
  logic signed [BND_W-1:0] lft_r, lft_nxt;
  logic signed [BND_W-1:0] rgt_r, rgt_nxt;
  logic signed [BND_W-1:0] cur_r, cur_nxt;
  side_t                   side_r, side_nxt;
  logic signed [BND_W-1:0] adv_top, adv_bot, adv_lft, adv_rgt, adv_cur;
  side_t                   adv_side;
  logic                    turn;
  logic signed [BND_W-1:0] row_s, col_s;

  always_comb begin
    adv_top  = top_r;
    adv_bot  = bot_r;
    adv_lft  = lft_r;
    adv_rgt  = rgt_r;
    adv_cur  = cur_r;
    adv_side = side_r;
    turn     = 1'b0;
    row_s    = top_r;
    col_s    = cur_r;
    case (side_r)
      SD_TOP: begin
        row_s = top_r;
        col_s = cur_r;
        if (cur_r < rgt_r) begin
          adv_cur = cur_r + BND_W'(1);
        end else begin
          turn     = 1'b1;
          adv_top  = top_r + BND_W'(1);
          adv_side = SD_RIGHT;
          adv_cur  = adv_top;
        end
      end
      SD_RIGHT: begin
        row_s = cur_r;
        col_s = rgt_r;
        if (cur_r < bot_r) begin
          adv_cur = cur_r + BND_W'(1);
        end else begin
          turn     = 1'b1;
          adv_rgt  = rgt_r - BND_W'(1);
          adv_side = SD_BOTTOM;
          adv_cur  = adv_rgt;
        end
      end
      SD_BOTTOM: begin
        row_s = bot_r;
        col_s = cur_r;
        if (cur_r > lft_r) begin
          adv_cur = cur_r - BND_W'(1);
        end else begin
          turn     = 1'b1;
          adv_bot  = bot_r - BND_W'(1);
          adv_side = SD_LEFT;
          adv_cur  = adv_bot;
        end
      end
      SD_LEFT: begin
        row_s = cur_r;
        col_s = lft_r;
        if (cur_r > top_r) begin
          adv_cur = cur_r - BND_W'(1);
        end else begin
          turn     = 1'b1;
          adv_lft  = lft_r + BND_W'(1);
          adv_side = SD_TOP;
          adv_cur  = adv_lft;
        end
      end
      default: begin
        adv_side = SD_TOP;
      end
    endcase
  end

  always_comb begin
    stat.last    = turn && !((adv_top <= adv_bot) && (adv_lft <= adv_rgt));
    stat.rd_addr = ADDR_W'(32'(row_s[DIM_W-1:0]) * MAX_DIM + 32'(col_s[DIM_W-1:0]));
  end

  always_comb begin
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    lft_nxt  = lft_r;
    rgt_nxt  = rgt_r;
    cur_nxt  = cur_r;
    side_nxt = side_r;
    if (start) begin
      top_nxt  = '0;
      bot_nxt  = BND_W'(rows) - BND_W'(1);
      lft_nxt  = '0;
      rgt_nxt  = BND_W'(cols) - BND_W'(1);
      cur_nxt  = '0;
      side_nxt = SD_TOP;
    end else if (step) begin
      top_nxt  = adv_top;
      bot_nxt  = adv_bot;
      lft_nxt  = adv_lft;
      rgt_nxt  = adv_rgt;
      cur_nxt  = adv_cur;
      side_nxt = adv_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      bot_r  <= '0;
      lft_r  <= '0;
      rgt_r  <= '0;
      cur_r  <= '0;
      side_r <= SD_TOP;
    end else begin
      top_r  <= top_nxt;
      bot_r  <= bot_nxt;
      lft_r  <= lft_nxt;
      rgt_r  <= rgt_nxt;
      cur_r  <= cur_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

### src/spiral_order_matrix_scan_unit.sv
// ----------------------------------------------------------------------------
// Spiral order matrix scan unit
// Loads a matrix in row-major order and reads it back in clockwise spiral
// order, one element per fetch item.
// ----------------------------------------------------------------------------
// Load items and fetch items are each taken at one per cycle while no
// divide runs and the output is not stalled; a fetch result passes
// through the registered read port of the element store and then the
// output register. A write to the column count register starts a serial
// divide that rebuilds the load position, and no item is taken while it
// runs. The 4096-word element store is not cleared after reset, so no
// clearing pass delays the first item.
module spiral_order_matrix_scan_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sosc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sosc_pkg::DIMV_W-1:0]          cfg_data,
  sosc_in_if.sink                              in_ch,
  sosc_out_if.source                           out_ch
);
  import sosc_pkg::*;

  logic [DIMV_W-1:0]        num_rows_r, num_cols_r;
  logic [DIM_W:0]           rows, cols;
  phase_t                   phase_r, phase_nxt;
  logic                     in_fire, load_fire, fetch_fire, cols_wr;
  logic                     move;
  logic                     pend_r, pend_nxt;
  logic                     pend_last_r;
  logic                     out_valid_r;
  logic signed [ELEM_W-1:0] out_element_r;
  logic                     out_is_last_r;
  logic [DATA_WIDTH-1:0]    rdata;
  ld_stat_t                 ld;
  wk_stat_t                 wk;

  assign rows    = clamp_dim(num_rows_r);
  assign cols    = clamp_dim(num_cols_r);
  assign move    = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cols_wr = cfg_we && (cfg_index == REG_NUM_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIMV_W'(1);
      num_cols_r <= DIMV_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows_r <= cfg_data;
        REG_NUM_COLS: num_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LOAD: begin
        if (load_fire && ld.full) begin
          phase_nxt = PH_EMIT;
        end
      end
      PH_EMIT: begin
        if (fetch_fire && wk.last) begin
          phase_nxt = PH_LOAD;
        end
      end
      default: phase_nxt = PH_LOAD;
    endcase
  end

  always_comb begin
    in_ch.ready = !ld.busy && (!pend_r || move);
    load_fire   = 1'b0;
    fetch_fire  = 1'b0;
    case (phase_r)
      PH_LOAD:  load_fire  = in_fire && !in_ch.action;
      PH_EMIT:  fetch_fire = in_fire && in_ch.action;
      default: ;
    endcase
  end

  sosc_loader u_loader (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_fire (load_fire),
    .cols_wr   (cols_wr),
    .rows      (rows),
    .cols      (cols),
    .stat      (ld)
  );

  sosc_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load_fire && ld.full),
    .step  (fetch_fire),
    .rows  (rows),
    .cols  (cols),
    .stat  (wk)
  );

  sosc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ld.wr_en),
    .waddr (ld.wr_addr),
    .wdata (DATA_WIDTH'(in_ch.element_in)),
    .re    (fetch_fire),
    .raddr (wk.rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (fetch_fire) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      if (pend_r && move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_fire) begin
      pend_last_r <= wk.last;
    end
    if (pend_r && move) begin
      out_element_r <= ELEM_W'(rdata);
      out_is_last_r <= pend_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.element_out = out_element_r;
  assign out_ch.is_last     = out_is_last_r;

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !move |=> pend_r)
    else $error("pending element lost while the output is stalled");

  a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    ld.busy |-> !in_ch.ready)
    else $error("item taken while the load position is being rebuilt");

  a_load_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LOAD && !pend_r |=> !pend_r)
    else $error("element read issued during the load phase");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_fire && wk.last |=> phase_r == PH_LOAD)
    else $error("emit phase kept after the final element");

endmodule

### dv/tb_spiral_order_matrix_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix scan unit testbench
// Loads matrices of random size and content, fetches them back and checks
// every element and its last flag against a cycle-free model of the spiral
// walk or the table. Directed items come first, then fixed and random passes.
// ----------------------------------------------------------------------------
module tb_spiral_order_matrix_scan_unit;
  import sosc_pkg::*;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_FETCH     = 1'b1;
  localparam int   RANDOM_ITEMS  = 450;
  localparam int   QUIET_ITEMS   = 380;
  localparam int   IDLE_LIMIT    = 2000;
  localparam int   HOLD_CYCLES   = 80;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     is_last;
  } scan_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [DIMV_W-1:0]        reg_val;
    logic                     action;
    logic signed [ELEM_W-1:0] element;
    logic                     typed;
    scan_result_t             want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIMV_W-1:0]    cfg_data;

  sosc_in_if  in_if ();
  sosc_out_if out_if ();

  spiral_order_matrix_scan_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Model of the scanner.
  logic signed [ELEM_W-1:0] elem_mem [DEPTH];
  bit                       elem_written [DEPTH];
  logic [DIMV_W-1:0]        rows_q;
  logic [DIMV_W-1:0]        cols_q;
  int                       load_cnt;
  phase_t                   scan_phase;
  side_t                    side;
  int                       top_b;
  int                       bot_b;
  int                       left_b;
  int                       right_b;
  int                       cur;

  scan_result_t pending_elems[$];
  stim_row_t    dir_tbl[$];

  bit gaps_on;
  bit hold_req;
  int load_items;
  int fetch_items;
  int ignored_items;
  int passes;
  int results_seen;
  int mismatches;
  int holds_done;
  int rows_max;
  int cols_max;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int dim_eff(input logic [DIMV_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic bit scan_predict(input logic act, input logic signed [ELEM_W-1:0] elem,
                                      output scan_result_t res);
    int rows;
    int cols;
    int r;
    int c;
    bit turned;
    rows = dim_eff(rows_q);
    cols = dim_eff(cols_q);
    res = '0;
    if (act == ACT_LOAD) begin
      if (scan_phase == PH_EMIT) return 1'b0;
      r = load_cnt / cols;
      c = load_cnt % cols;
      if (r < MAX_DIM) begin
        elem_mem[r * MAX_DIM + c] = elem;
        elem_written[r * MAX_DIM + c] = 1'b1;
      end
      load_cnt = (load_cnt + 1) % (1 << CNT_W);
      if (load_cnt >= rows * cols) begin
        scan_phase = PH_EMIT;
        load_cnt = 0;
        top_b = 0;
        bot_b = rows - 1;
        left_b = 0;
        right_b = cols - 1;
        side = SD_TOP;
        cur = 0;
        if (rows > rows_max) rows_max = rows;
        if (cols > cols_max) cols_max = cols;
      end
      return 1'b0;
    end
    if (scan_phase == PH_LOAD) return 1'b0;
    case (side)
      SD_TOP: begin
        r = top_b;
        c = cur;
      end
      SD_RIGHT: begin
        r = cur;
        c = right_b;
      end
      SD_BOTTOM: begin
        r = bot_b;
        c = cur;
      end
      default: begin
        r = cur;
        c = left_b;
      end
    endcase
    res.element = elem_mem[r * MAX_DIM + c];
    turned = 1'b0;
    case (side)
      SD_TOP: begin
        if (cur < right_b) cur++;
        else begin
          top_b++;
          side = SD_RIGHT;
          cur = top_b;
          turned = 1'b1;
        end
      end
      SD_RIGHT: begin
        if (cur < bot_b) cur++;
        else begin
          right_b--;
          side = SD_BOTTOM;
          cur = right_b;
          turned = 1'b1;
        end
      end
      SD_BOTTOM: begin
        if (cur > left_b) cur--;
        else begin
          bot_b--;
          side = SD_LEFT;
          cur = bot_b;
          turned = 1'b1;
        end
      end
      default: begin
        if (cur > top_b) cur--;
        else begin
          left_b++;
          side = SD_TOP;
          cur = left_b;
          turned = 1'b1;
        end
      end
    endcase
    res.is_last = turned && !(top_b <= bot_b && left_b <= right_b);
    if (res.is_last) begin
      scan_phase = PH_LOAD;
      load_cnt = 0;
    end
    return 1'b1;
  endfunction

  // A dimension change in mid-load is only safe if the spiral will read no
  // entry that was never loaded.
  function automatic bit reads_covered(input int rows, input int cols);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (r * cols + c < load_cnt && !elem_written[r * MAX_DIM + c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(ELEM_W-1){1'b1}}};
      1: return {1'b1, {(ELEM_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIMV_W-1:0] pick_dim();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return DIMV_W'($urandom_range(1, 5));
    if (k < 88) return DIMV_W'($urandom_range(6, 12));
    if (k < 94) return DIMV_W'($urandom_range(13, 24));
    if (k < 97) return '0;
    return DIMV_W'($urandom_range(64, 127));
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DIMV_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic act, input logic signed [ELEM_W-1:0] elem);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.action = act;
    row.element = elem;
    return row;
  endfunction

  function automatic stim_row_t fetch_row(input logic signed [ELEM_W-1:0] elem_want,
                                          input logic last_want);
    stim_row_t row;
    row = item_row(ACT_FETCH, '0);
    row.typed = 1'b1;
    row.want.element = elem_want;
    row.want.is_last = last_want;
    return row;
  endfunction

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic act, input logic signed [ELEM_W-1:0] elem,
                           input bit typed, input scan_result_t want);
    scan_result_t res;
    bit got;
    bit ignored;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.element_in <= elem;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ignored = (act == ACT_LOAD) == (scan_phase == PH_EMIT);
    got = scan_predict(act, elem, res);
    if (typed) pending_elems.push_back(want);
    else if (got) pending_elems.push_back(res);
    if (ignored) ignored_items++;
    else if (act == ACT_LOAD) load_items++;
    else fetch_items++;
    if (gaps_on && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 5));
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIMV_W-1:0] val);
    wait_drained(SETTLE_CYCLES);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_ROWS) rows_q = val;
    else cols_q = val;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_all(input bit allow_mid);
    int n;
    int mid_at;
    int tries;
    logic [DIMV_W-1:0] nr;
    logic [DIMV_W-1:0] nc;
    n = 0;
    mid_at = -1;
    if (allow_mid && $urandom_range(0, 7) == 0)
      mid_at = $urandom_range(0, dim_eff(rows_q) * dim_eff(cols_q) - 1);
    while (scan_phase == PH_LOAD) begin
      if (n == mid_at) begin
        for (tries = 0; tries < 8; tries++) begin
          nr = DIMV_W'($urandom_range(1, 6));
          nc = DIMV_W'($urandom_range(1, 6));
          if (reads_covered(dim_eff(nr), dim_eff(nc))) break;
        end
        if (tries < 8) begin
          write_reg(REG_NUM_ROWS, nr);
          write_reg(REG_NUM_COLS, nc);
        end
      end
      if ($urandom_range(0, 11) == 0) send_item(ACT_FETCH, rand_elem(), 1'b0, '0);
      send_item(ACT_LOAD, rand_elem(), 1'b0, '0);
      n++;
    end
  endtask

  task automatic fetch_all(input bit hold_out);
    int n;
    int total;
    int mid_at;
    int pause_at;
    n = 0;
    total = dim_eff(rows_q) * dim_eff(cols_q);
    mid_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
    pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1) : -1;
    if (hold_out) begin
      hold_req = 1'b1;
      pause_at = total / 2;
    end
    while (scan_phase == PH_EMIT) begin
      if (n == mid_at) begin
        write_reg(REG_NUM_ROWS, DIMV_W'($urandom_range(0, 127)));
        write_reg(REG_NUM_COLS, DIMV_W'($urandom_range(0, 127)));
      end
      if (n == pause_at) wait_drained(0);
      if ($urandom_range(0, 11) == 0) send_item(ACT_LOAD, rand_elem(), 1'b0, '0);
      send_item(ACT_FETCH, rand_elem(), 1'b0, '0);
      n++;
    end
    passes++;
  endtask

  task automatic scan_pass(input logic [DIMV_W-1:0] rows_raw, input logic [DIMV_W-1:0] cols_raw,
                           input bit hold_out);
    write_reg(REG_NUM_ROWS, rows_raw);
    write_reg(REG_NUM_COLS, cols_raw);
    load_all(!hold_out);
    fetch_all(hold_out);
  endtask

  initial begin : receiver
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected element %0d (last %0b) with nothing outstanding.",
                   out_if.element_out, out_if.is_last);
      end else begin
        want = pending_elems.pop_front();
        if (out_if.element_out !== want.element || out_if.is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Element %0d: expected %0d (last %0b), got %0d (last %0b).",
                     results_seen, want.element, want.is_last,
                     out_if.element_out, out_if.is_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("No handshake for %0d cycles, %0d elements outstanding.",
               IDLE_LIMIT, pending_elems.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    logic [DIMV_W-1:0] nr;
    logic [DIMV_W-1:0] nc;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NUM_ROWS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_LOAD;
    in_if.element_in = '0;
    gaps_on = 1'b0;
    hold_req = 1'b0;
    rows_q = DIMV_W'(1);
    cols_q = DIMV_W'(1);
    load_cnt = 0;
    scan_phase = PH_LOAD;
    side = SD_TOP;
    top_b = 0;
    bot_b = 0;
    left_b = 0;
    right_b = 0;
    cur = 0;

    // The block starts as a one by one matrix in the loading phase.
    dir_tbl = {
      item_row(ACT_FETCH, 32'sh0000_0001),
      item_row(ACT_LOAD, 32'sh7FFF_FFFF),
      item_row(ACT_LOAD, -32'sd1),
      fetch_row(32'sh7FFF_FFFF, 1'b1),
      cfg_row(REG_NUM_ROWS, 7'd0),
      cfg_row(REG_NUM_COLS, 7'd2),
      item_row(ACT_LOAD, 32'sh8000_0000),
      item_row(ACT_LOAD, 32'sh0000_0000),
      fetch_row(32'sh8000_0000, 1'b0),
      cfg_row(REG_NUM_ROWS, 7'd2),
      fetch_row(32'sh0000_0000, 1'b1),
      item_row(ACT_LOAD, 32'sh1234_5678),
      cfg_row(REG_NUM_ROWS, 7'd1),
      item_row(ACT_LOAD, 32'sh0F0F_0F0F),
      item_row(ACT_FETCH, 32'sh0000_0000),
      item_row(ACT_FETCH, 32'sh0000_0000),
      cfg_row(REG_NUM_ROWS, 7'd2),
      item_row(ACT_LOAD, 32'shA5A5_A5A5),
      item_row(ACT_LOAD, -32'sd1),
      item_row(ACT_LOAD, 32'sh0000_0001),
      item_row(ACT_LOAD, 32'sh5A5A_5A5A),
      item_row(ACT_FETCH, 32'sh0000_0000),
      item_row(ACT_FETCH, 32'sh0000_0000),
      item_row(ACT_FETCH, 32'sh0000_0000),
      item_row(ACT_FETCH, 32'sh0000_0000)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
      else send_item(dir_tbl[i].action, dir_tbl[i].element, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Full-height single column, then a partial 64 by 64 load cut short by
    // dropping the column count to one, so the next load lands beyond the
    // last row and is dropped.
    scan_pass(7'd65, 7'd1, 1'b0);
    write_reg(REG_NUM_ROWS, 7'd64);
    write_reg(REG_NUM_COLS, 7'd64);
    repeat (70) send_item(ACT_LOAD, rand_elem(), 1'b0, '0);
    write_reg(REG_NUM_COLS, 7'd1);
    load_all(1'b0);
    fetch_all(1'b0);

    // Full-width single row with the receiver held off long enough to
    // back up the input.
    gaps_on = 1'b0;
    scan_pass(7'd1, 7'd127, 1'b1);

    base = load_items + fetch_items;
    while (load_items + fetch_items < base + RANDOM_ITEMS) begin
      gaps_on = (load_items + fetch_items < base + QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      nr = pick_dim();
      nc = pick_dim();
      if (dim_eff(nr) * dim_eff(nc) > 300) nc = DIMV_W'($urandom_range(1, 4));
      scan_pass(nr, nc, 1'b0);
    end

    gaps_on = 1'b0;
    wait_drained(12);
    $display("Ran %0d matrix passes up to %0d rows and %0d columns: %0d loads, %0d fetches.",
             passes, rows_max, cols_max, load_items, fetch_items);
    $display("Ignored items: %0d, long output hold-offs: %0d, elements checked: %0d.",
             ignored_items, holds_done, results_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
src/sosc_pkg.sv
src/sosc_if.sv
src/sosc_ram.sv
src/sosc_loader.sv
src/sosc_walker.sv
src/spiral_order_matrix_scan_unit.sv
dv/tb_spiral_order_matrix_scan_unit.sv
